[src/varf_pkg.sv]
// Package: constants and types shared by the residual filter modules.
`default_nettype none
package varf_pkg;
    localparam int CHANNELS  = 4;
    localparam int MAX_ORDER = 4;
    localparam int TAPS      = MAX_ORDER * CHANNELS;
    localparam int TABLE_SIZE = MAX_ORDER * CHANNELS * CHANNELS;
    localparam int CH_W      = $clog2(CHANNELS);
    localparam int LAG_W     = $clog2(MAX_ORDER);
    localparam int TAP_W     = $clog2(TAPS);
    localparam int IDX_W     = 6;
    localparam int SMP_W     = 16;
    localparam int COEF_W    = 16;
    localparam int RES_W     = 18;
    localparam int PROD_W    = SMP_W + COEF_W;
    localparam int ACC_W     = 40;
    localparam int FRAC_BITS = 14;
    localparam int RES_MAX   = 131071;
    localparam int RES_MIN   = -131072;

    localparam logic [0:0] REQ_LOAD   = 1'b0;
    localparam logic [0:0] REQ_SAMPLE = 1'b1;
    localparam logic [0:0] CFG_ORDER    = 1'b0;
    localparam logic [0:0] CFG_CHANNELS = 1'b1;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

    typedef struct packed {
        logic                 clear;   // load x*2^14 into accumulator
        logic                 enable;  // subtract one registered product from the accumulator
    } lane_ctrl_t;
endpackage
`default_nettype wire

[src/varf_cell.sv]
// One channel lane: coefficient row, registered product and accumulator.
`default_nettype none
module varf_cell (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire varf_pkg::lane_ctrl_t               ctrl,
    input  wire logic                               coef_we,
    input  wire logic [varf_pkg::TAP_W-1:0]         coef_waddr,
    input  wire logic signed [varf_pkg::COEF_W-1:0] coef_wdata,
    input  wire logic [varf_pkg::TAP_W-1:0]         tap_addr,
    input  wire logic signed [varf_pkg::SMP_W-1:0]  x_in,
    input  wire logic signed [varf_pkg::SMP_W-1:0]  hist_in,
    output logic signed [varf_pkg::ACC_W-1:0]       acc_out
);
    import varf_pkg::*;
    // coefficients of this output channel, addressed lag*CHANNELS + in_ch
    logic signed [COEF_W-1:0] coef_reg [TAPS];
    logic signed [PROD_W-1:0] prod_reg;
    logic                     pen_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    always_comb begin
        acc_next = acc_reg;
        if (ctrl.clear) begin
            acc_next = ACC_W'(x_in) <<< FRAC_BITS;
        end else if (pen_reg) begin
            acc_next = acc_reg - ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int t = 0; t < TAPS; t++) coef_reg[t] <= '0;
            pen_reg <= 1'b0;
        end else begin
            if (coef_we) coef_reg[coef_waddr] <= coef_wdata;
            pen_reg <= ctrl.enable;
        end
        prod_reg <= coef_reg[tap_addr] * hist_in;
        acc_reg  <= acc_next;
    end
    assign acc_out = acc_reg;
endmodule
`default_nettype wire

[src/var_residual_filter.sv]
// Top level: VAR residual filter with four channel cells sharing a history shift line.
// Usage:
// s_ channel takes items: tuser = req_type; tdata = coef_index[5:0],
// coef_value[21:6], sample_ch0..3 from bit 22 up (zero padded to 88 bits).
// A load writes one coefficient word into the cell of its output channel and
// gives no result; a sample that only fills history gives none either, and the
// block stays idle for the next item. A sample that gives a result runs its
// multiply-accumulates over order*channels taps (up to 16) in all four cells at
// once (one product per cell per cycle), then drains the last products and
// saturates; the next item is taken only once the result is in the output register.
// History shifts as a chain: each sample enters lag 0 and pushes older ones on.
// m_ channel: tdata = residual_ch0..3 (18 bits each, ch0 lowest), tuser = saturated.
// The result waits in an output register while m_tready is low; the next sample
// is still computed, then held with the input stalled until that register frees.
// cfg_ channel: index 0 active_order, 1 active_channels; write while idle.
// Reset (aresetn low, synchronous) clears coefficients, history, fill count and
// sets the registers to order 4, channels 4.
`default_nettype none
module var_residual_filter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [87:0] s_tdata,   // coef_index, coef_value, sample_ch0..3
    input  wire logic        s_tuser,   // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // residual_ch0..3
    output logic             m_tuser,   // saturated
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [2:0]  cfg_data
);
    import varf_pkg::*;

    logic signed [SMP_W-1:0]  hist_reg [MAX_ORDER][CHANNELS];
    logic signed [SMP_W-1:0]  x_reg [CHANNELS];
    logic [2:0] order_reg, chans_reg, fill_reg;
    state_t state_reg, state_next;
    logic [TAP_W:0] tap_reg;
    logic [2:0] drain_reg;
    logic [2:0] ord_c, ch_c;
    logic [TAP_W:0] taps;
    logic s_acc;
    logic load_acc;
    logic [TAP_W-1:0] coef_waddr;
    lane_ctrl_t ctrl;
    logic signed [ACC_W-1:0] acc [CHANNELS];
    logic [LAG_W-1:0] lag;
    logic [CH_W-1:0]  inc;
    logic [RES_W*CHANNELS-1:0] res_pack;
    logic [CHANNELS-1:0] sat_v;
    logic out_valid_reg;
    logic out_load;

    assign ord_c = (order_reg > 3'(MAX_ORDER)) ? 3'(MAX_ORDER) : order_reg;
    assign ch_c  = (chans_reg > 3'(CHANNELS)) ? 3'(CHANNELS) : chans_reg;
    assign taps  = (TAP_W+1)'(ord_c) * (TAP_W+1)'(ch_c);
    assign lag   = tap_reg[TAP_W-1:CH_W];
    assign inc   = tap_reg[CH_W-1:0];
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_acc = s_tvalid && s_tready;
    assign load_acc = s_acc && s_tuser == REQ_LOAD;
    assign coef_waddr = {s_tdata[5:4], s_tdata[1:0]};
    assign out_load = (state_reg == ST_DONE) && (drain_reg == 3'd2) &&
                      (!out_valid_reg || m_tready);

    // tap counter walks lag-major with in-channel minor, skipping unused channels
    logic [TAP_W:0] tap_next;
    always_comb begin
        tap_next = tap_reg + 1'b1;
        if ((TAP_W+1)'(inc) + 1'b1 >= (TAP_W+1)'(ch_c))
            tap_next = (TAP_W+1)'({lag, {CH_W{1'b0}}}) + (TAP_W+1)'(CHANNELS);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_acc && s_tuser == REQ_SAMPLE && fill_reg >= ord_c) begin
                state_next = (taps == 0) ? ST_DONE : ST_RUN;
            end
            ST_RUN:  if (tap_next >= (TAP_W+1)'(ord_c) << CH_W || ch_c == 0) begin
                state_next = ST_DONE;
            end
            ST_DONE: if (out_load) begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl.clear  = (state_reg == ST_IDLE) && s_acc && s_tuser == REQ_SAMPLE;
        ctrl.enable = (state_reg == ST_RUN) && ch_c != 0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            order_reg  <= 3'd4;
            chans_reg  <= 3'd4;
            fill_reg   <= '0;
            tap_reg    <= '0;
            drain_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int l = 0; l < MAX_ORDER; l++)
                for (int c = 0; c < CHANNELS; c++) hist_reg[l][c] <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                if (cfg_index == CFG_ORDER) order_reg <= cfg_data;
                else chans_reg <= cfg_data;
            end
            tap_reg   <= (state_reg == ST_RUN) ? tap_next : '0;
            // hold the drain count at two while the output register is busy
            if (state_reg != ST_DONE) drain_reg <= '0;
            else if (drain_reg != 3'd2) drain_reg <= drain_reg + 1'b1;
            if (out_load) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
            // history advances once the sample's products are all started
            if ((state_reg == ST_IDLE && s_acc && s_tuser == REQ_SAMPLE &&
                 state_next == ST_IDLE) ||
                (state_reg == ST_RUN && state_next == ST_DONE) ||
                (state_reg == ST_IDLE && state_next == ST_DONE)) begin
                for (int l = MAX_ORDER - 1; l > 0; l--) hist_reg[l] <= hist_reg[l-1];
                for (int c = 0; c < CHANNELS; c++)
                    hist_reg[0][c] <= (state_reg == ST_IDLE) ?
                        s_tdata[22 + c*SMP_W +: SMP_W] : x_reg[c];
                if (fill_reg < 3'(MAX_ORDER)) fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.clear)
            for (int c = 0; c < CHANNELS; c++) x_reg[c] <= s_tdata[22 + c*SMP_W +: SMP_W];
    end

    for (genvar k = 0; k < CHANNELS; k++) begin : g_lane
        logic coef_we;
        logic signed [ACC_W-1:0] q;
        logic signed [RES_W-1:0] r;
        logic hi, lo;
        assign coef_we = load_acc && (s_tdata[3:2] == CH_W'(k));
        varf_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .coef_we   (coef_we),
            .coef_waddr(coef_waddr),
            .coef_wdata(s_tdata[21:6]),
            .tap_addr  (tap_reg[TAP_W-1:0]),
            .x_in      (s_tdata[22 + k*SMP_W +: SMP_W]),
            .hist_in   (hist_reg[lag][inc]),
            .acc_out   (acc[k])
        );
        assign q  = acc[k] >>> FRAC_BITS;
        assign hi = q > ACC_W'(RES_MAX);
        assign lo = q < ACC_W'(RES_MIN);
        assign r  = hi ? RES_W'(RES_MAX) : lo ? RES_W'(RES_MIN) : RES_W'(q);
        assign res_pack[k*RES_W +: RES_W] = (3'(k) < ch_c) ? r : '0;
        assign sat_v[k] = (3'(k) < ch_c) && (hi || lo);
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata <= res_pack;
            m_tuser <= |sat_v;
        end
    end
    assign m_tvalid = out_valid_reg;
endmodule
`default_nettype wire
